@@ hdl/vt4_pkg.sv @@
package vt4_pkg;

  localparam int unsigned DIM      = 4;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = 2 * COORD_W;
  localparam int unsigned PAIR_W   = PROD_W + 1;
  localparam int unsigned ROW_W    = PROD_W + 2;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W    = 2 * COORD_W;
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [DIM-1:0]          vec_t;
  typedef vec_t   [DIM-1:0]          mat_t;

  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef prod_t  [DIM-1:0]          prod_row_t;
  typedef prod_row_t [DIM-1:0]       prod_mat_t;

  typedef logic signed [PAIR_W-1:0]  pair_t;
  typedef pair_t  [1:0]              pair_row_t;
  typedef pair_row_t [DIM-1:0]       pair_mat_t;

  typedef logic signed [ROW_W-1:0]   row_sum_t;
  typedef row_sum_t [DIM-1:0]        row_vec_t;

  typedef logic [REG_W-1:0]          cfg_word_t;
  typedef cfg_word_t [NUM_REGS-1:0]  cfg_bank_t;

  // Identity matrix after reset (index 7 first)
  localparam cfg_bank_t CFG_RESET = {
    64'h0001_0000_0000_0000, 64'h0,
    64'h0000_0000_0001_0000, 64'h0,
    64'h0,                   64'h0001_0000_0000_0000,
    64'h0,                   64'h0000_0000_0001_0000
  };

endpackage

@@ hdl/vt4_mul.sv @@
module vt4_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              ready_o,
  input  vt4_pkg::vec_t     pt_i,
  input  vt4_pkg::mat_t     mat_i,
  output logic              valid_o,
  input  logic              ready_i,
  output vt4_pkg::prod_mat_t prod_o
);

  logic               vld_r;
  vt4_pkg::prod_mat_t prod_r;
  logic               adv;

  assign adv     = !vld_r || ready_i;
  assign ready_o = adv;
  assign valid_o = vld_r;
  assign prod_o  = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= valid_i;
    end
  end

  // One 32x32 signed multiplier per coefficient; sign-extend both operands so the
  // full 64-bit product is kept
  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      for (int r = 0; r < vt4_pkg::DIM; r++) begin
        for (int c = 0; c < vt4_pkg::DIM; c++) begin
          prod_r[r][c] <= vt4_pkg::prod_t'($signed(mat_i[r][c]))
                        * vt4_pkg::prod_t'($signed(pt_i[c]));
        end
      end
    end
  end

endmodule

@@ hdl/vt4_sum.sv @@
module vt4_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  vt4_pkg::prod_mat_t prod_i,
  output logic               valid_o,
  input  logic               ready_i,
  output vt4_pkg::row_vec_t  sum_o
);

  logic               pair_vld_r;
  vt4_pkg::pair_mat_t pair_r;
  logic               row_vld_r;
  vt4_pkg::row_vec_t  row_r;
  logic               adv_pair;
  logic               adv_row;

  assign adv_row  = !row_vld_r || ready_i;
  assign adv_pair = !pair_vld_r || adv_row;
  assign ready_o  = adv_pair;
  assign valid_o  = row_vld_r;
  assign sum_o    = row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_vld_r <= 1'b0;
      row_vld_r  <= 1'b0;
    end else begin
      if (adv_pair) begin
        pair_vld_r <= valid_i;
      end
      if (adv_row) begin
        row_vld_r <= pair_vld_r;
      end
    end
  end

  // First level: columns 0+1 and 2+3
  always_ff @(posedge clk) begin
    if (adv_pair && valid_i) begin
      for (int r = 0; r < vt4_pkg::DIM; r++) begin
        for (int h = 0; h < 2; h++) begin
          pair_r[r][h] <= {prod_i[r][2*h][vt4_pkg::PROD_W-1], prod_i[r][2*h]}
                        + {prod_i[r][2*h+1][vt4_pkg::PROD_W-1], prod_i[r][2*h+1]};
        end
      end
    end
  end

  // Second level: full row sum, exact
  always_ff @(posedge clk) begin
    if (adv_row && pair_vld_r) begin
      for (int r = 0; r < vt4_pkg::DIM; r++) begin
        row_r[r] <= {pair_r[r][0][vt4_pkg::PAIR_W-1], pair_r[r][0]}
                  + {pair_r[r][1][vt4_pkg::PAIR_W-1], pair_r[r][1]};
      end
    end
  end

endmodule

@@ hdl/vt4_sat.sv @@
module vt4_sat (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              ready_o,
  input  vt4_pkg::row_vec_t sum_i,
  output logic              valid_o,
  input  logic              ready_i,
  output vt4_pkg::vec_t     coord_o,
  output logic              clipped_o
);

  localparam int unsigned Q_W = vt4_pkg::ROW_W - vt4_pkg::FRAC_W;
  localparam int unsigned TOP_W = Q_W - vt4_pkg::COORD_W + 1;

  logic               vld_r;
  vt4_pkg::vec_t      coord_r;
  logic               clip_r;
  vt4_pkg::vec_t      coord_nxt;
  logic [vt4_pkg::DIM-1:0] ovf;
  logic               adv;

  assign adv       = !vld_r || ready_i;
  assign ready_o   = adv;
  assign valid_o   = vld_r;
  assign coord_o   = coord_r;
  assign clipped_o = clip_r;

  // Drop the fraction (floor), then clamp to 32-bit signed
  always_comb begin
    logic [Q_W-1:0]   q;
    logic [TOP_W-1:0] top;
    for (int r = 0; r < vt4_pkg::DIM; r++) begin
      q   = sum_i[r][vt4_pkg::ROW_W-1:vt4_pkg::FRAC_W];
      top = q[Q_W-1:vt4_pkg::COORD_W-1];
      ovf[r] = !((top == '0) || (top == '1));
      if (!ovf[r]) begin
        coord_nxt[r] = vt4_pkg::coord_t'(q[vt4_pkg::COORD_W-1:0]);
      end else if (q[Q_W-1]) begin
        coord_nxt[r] = {1'b1, {(vt4_pkg::COORD_W-1){1'b0}}};
      end else begin
        coord_nxt[r] = {1'b0, {(vt4_pkg::COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      coord_r <= coord_nxt;
      clip_r  <= |ovf;
    end
  end

endmodule

@@ hdl/vertex_transform_4x4.sv @@
// Transforms one homogeneous point (x, y, z, w, Q16.16 signed) per request by the
// 4x4 Q16.16 matrix held in eight 64-bit configuration registers (two coefficients
// each, even column in the low half); reset loads the identity. Each output
// coordinate is the exact sum of four full-width products, floored by 2^16 and
// clamped to 32-bit signed; out_tuser flags that at least one coordinate clamped.
// The block takes one point per cycle while out_tready is high; an accepted point
// is offered on out_tvalid after passing five register stages: input register,
// sixteen parallel 32x32 multipliers, two adder-tree levels and the clamp/output
// register. Every stage keeps its own valid bit and advances when it is empty or
// the next stage moves, so bubbles collapse under back-pressure and no request is
// dropped or repeated. Write the matrix only while the pipeline is empty; writes to
// indexes 8 to 15 are ignored.
module vertex_transform_4x4 (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream: tdata = {in_w, in_z, in_y, in_x}, in_x in bits 31:0
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  // Result stream: tdata = {out_w, out_z, out_y, out_x}, out_x in bits 31:0
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,
  // tuser bit 0: clipped
  output logic         out_tuser,
  // Configuration write port
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  vt4_pkg::cfg_bank_t  cfg_r;
  vt4_pkg::mat_t       mat;

  logic                pt_vld_r;
  vt4_pkg::vec_t       pt_r;
  logic                adv_in;

  logic                mul_ready;
  logic                mul_valid;
  vt4_pkg::prod_mat_t  prod;
  logic                sum_ready;
  logic                sum_valid;
  vt4_pkg::row_vec_t   row_sum;
  logic                sat_ready;
  vt4_pkg::vec_t       coord;
  logic                clipped;

  // Hold the matrix; ignore indexes past the last register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= vt4_pkg::CFG_RESET;
    end else if (cfg_we && !cfg_index[vt4_pkg::CFG_IDX_W-1]) begin
      cfg_r[cfg_index[vt4_pkg::CFG_IDX_W-2:0]] <= cfg_wdata;
    end
  end

  // Unpack: register 2r+c/2 carries row r, even column low, odd column high
  always_comb begin
    for (int r = 0; r < vt4_pkg::DIM; r++) begin
      for (int h = 0; h < 2; h++) begin
        mat[r][2*h]   = cfg_r[2*r+h][vt4_pkg::COORD_W-1:0];
        mat[r][2*h+1] = cfg_r[2*r+h][vt4_pkg::REG_W-1:vt4_pkg::COORD_W];
      end
    end
  end

  // Input register stage
  assign adv_in    = !pt_vld_r || mul_ready;
  assign in_tready = adv_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_vld_r <= 1'b0;
    end else if (adv_in) begin
      pt_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_tvalid) begin
      for (int c = 0; c < vt4_pkg::DIM; c++) begin
        pt_r[c] <= in_tdata[c*vt4_pkg::COORD_W +: vt4_pkg::COORD_W];
      end
    end
  end

  vt4_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (pt_vld_r),
    .ready_o (mul_ready),
    .pt_i    (pt_r),
    .mat_i   (mat),
    .valid_o (mul_valid),
    .ready_i (sum_ready),
    .prod_o  (prod)
  );

  vt4_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (mul_valid),
    .ready_o (sum_ready),
    .prod_i  (prod),
    .valid_o (sum_valid),
    .ready_i (sat_ready),
    .sum_o   (row_sum)
  );

  vt4_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (sum_valid),
    .ready_o   (sat_ready),
    .sum_i     (row_sum),
    .valid_o   (out_tvalid),
    .ready_i   (out_tready),
    .coord_o   (coord),
    .clipped_o (clipped)
  );

  assign out_tdata = {coord[3], coord[2], coord[1], coord[0]};
  assign out_tuser = clipped;

endmodule
